### design/utf8tc_pkg.sv
package utf8tc_pkg;

  localparam logic [7:0] BYTE_SPACE   = 8'h20;
  localparam logic [7:0] BYTE_ZERO    = 8'h00;
  localparam logic [15:0] CJK_A_LO    = 16'h3400;
  localparam logic [15:0] CJK_A_HI    = 16'h4DBF;
  localparam logic [15:0] CJK_URO_LO  = 16'h4E00;
  localparam logic [15:0] CJK_URO_HI  = 16'h9FFF;
  localparam logic [15:0] CJK_CMP_LO  = 16'hF900;
  localparam logic [15:0] CJK_CMP_HI  = 16'hFAFF;
  localparam logic [7:0] MASK_TWO     = 8'hE0;
  localparam logic [7:0] MASK_THREE   = 8'hF0;
  localparam logic [7:0] MASK_FOUR    = 8'hF8;
  localparam logic [7:0] MASK_CONT    = 8'hC0;
  localparam logic [7:0] LEAD_CONT    = 8'h80;
  localparam logic [7:0] LEAD_TWO     = 8'hC0;
  localparam logic [7:0] LEAD_THREE   = 8'hE0;
  localparam logic [7:0] LEAD_FOUR    = 8'hF0;

  typedef enum logic [1:0] {
    VERDICT_EMPTY  = 2'd0,
    VERDICT_UTF8   = 2'd1,
    VERDICT_LEGACY = 2'd2
  } verdict_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    verdict_t verdict;
    logic     valid_utf8;
    logic     all_ascii;
    logic     has_cjk;
  } result_t;

  typedef struct packed {
    logic advance;
  } stage_ctl_t;

  function automatic logic in_cjk(input logic [15:0] u);
    in_cjk = (u >= CJK_A_LO && u <= CJK_A_HI) || (u >= CJK_URO_LO && u <= CJK_URO_HI) ||
             (u >= CJK_CMP_LO && u <= CJK_CMP_HI);
  endfunction

endpackage

### design/utf8tc_in_if.sv
interface utf8tc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_text;

  modport source(output valid, output data_byte, output end_of_text, input ready);
  modport sink(input valid, input data_byte, input end_of_text, output ready);
endinterface

### design/utf8tc_out_if.sv
interface utf8tc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;
  logic       valid_utf8;
  logic       all_ascii;
  logic       has_cjk;

  modport source(output valid, output verdict, output valid_utf8, output all_ascii,
                 output has_cjk, input ready);
  modport sink(input valid, input verdict, input valid_utf8, input all_ascii,
               input has_cjk, output ready);
endinterface

### design/utf8tc_in_stage.sv
module utf8tc_in_stage
  import utf8tc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  text_item_t in_item,
  input  logic       out_free,
  output stage_ctl_t ctl,
  output text_item_t item
);

  logic busy;

  assign ctl.advance = busy && (!item.end_of_text || out_free);
  assign in_ready    = !busy || ctl.advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (in_ready) begin
      busy <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

### design/utf8tc_core.sv
module utf8tc_core
  import utf8tc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl,
  input  text_item_t item,
  output result_t    result
);

  typedef struct packed {
    logic [1:0]  pending;
    logic        three_byte;
    logic [15:0] acc;
    logic        still_valid;
    logic        ascii;
    logic        cjk;
    logic        zero_seen;
    logic        nonspace;
  } field_state_t;

  localparam field_state_t STATE_INIT = '{
    pending: 2'd0, three_byte: 1'b0, acc: 16'd0, still_valid: 1'b1,
    ascii: 1'b1, cjk: 1'b0, zero_seen: 1'b0, nonspace: 1'b0
  };

  field_state_t st;
  field_state_t st_next;
  logic [7:0]   c;
  logic [15:0]  acc_shift;
  logic         ok;

  assign c         = item.data_byte;
  assign acc_shift = {st.acc[9:0], c[5:0]};

  always_comb begin
    st_next = st;
    if (!st.zero_seen) begin
      if (c == BYTE_ZERO) begin
        st_next.zero_seen = 1'b1;
      end else begin
        if (c != BYTE_SPACE) st_next.nonspace = 1'b1;
        if (c[7]) st_next.ascii = 1'b0;
        if (st.still_valid) begin
          if ((c & MASK_CONT) == LEAD_CONT) begin
            if (st.pending == 2'd0) begin
              st_next.still_valid = 1'b0;
            end else begin
              st_next.acc     = acc_shift;
              st_next.pending = st.pending - 2'd1;
              if (st.pending == 2'd1 && st.three_byte && in_cjk(acc_shift)) begin
                st_next.cjk = 1'b1;
              end
            end
          end else if (st.pending != 2'd0) begin
            st_next.still_valid = 1'b0;
          end else begin
            st_next.three_byte = 1'b0;
            st_next.acc        = 16'd0;
            if (c[7]) begin
              if ((c & MASK_TWO) == LEAD_TWO) begin
                st_next.pending = 2'd1;
              end else if ((c & MASK_THREE) == LEAD_THREE) begin
                st_next.pending    = 2'd2;
                st_next.three_byte = 1'b1;
                st_next.acc        = {12'd0, c[3:0]};
              end else if ((c & MASK_FOUR) == LEAD_FOUR) begin
                st_next.pending = 2'd3;
              end else begin
                st_next.still_valid = 1'b0;
              end
            end
          end
        end
      end
    end
  end

  assign ok                = st_next.still_valid && st_next.pending == 2'd0;
  assign result.valid_utf8 = ok;
  assign result.all_ascii  = st_next.ascii;
  assign result.has_cjk    = ok && st_next.cjk;

  always_comb begin
    if (!st_next.nonspace) begin
      result.verdict = VERDICT_EMPTY;
    end else if (ok && (st_next.ascii || st_next.cjk)) begin
      result.verdict = VERDICT_UTF8;
    end else begin
      result.verdict = VERDICT_LEGACY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_INIT;
    end else if (ctl.advance) begin
      st <= item.end_of_text ? STATE_INIT : st_next;
    end
  end

endmodule

### design/utf8tc_out_stage.sv
module utf8tc_out_stage
  import utf8tc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stage_ctl_t ctl,
  input  logic       last,
  input  result_t    result,
  input  logic       out_ready,
  output logic       out_valid,
  output logic       out_free,
  output result_t    out_result
);

  logic load;

  assign out_free = !out_valid || out_ready;
  assign load     = ctl.advance && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_result <= result;
    end
  end

endmodule

### design/utf8_text_classifier.sv
// Result path: the byte marked last is held in the input register, then its result
// is loaded into the output register (input register, then output register).
// Throughput: one byte per cycle; the input stalls only while a finished result
// waits in the output register and another last byte is held behind it.
// Reset (rst, synchronous, active high) clears the field state and empties both
// the input and output registers.
module utf8_text_classifier
  import utf8tc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  utf8tc_in_if.sink           text_in,
  utf8tc_out_if.source        result_out
);

  stage_ctl_t ctl;
  text_item_t in_item;
  text_item_t item;
  result_t    result;
  result_t    out_result;
  logic       out_free;

  assign in_item.data_byte   = text_in.data_byte;
  assign in_item.end_of_text = text_in.end_of_text;

  utf8tc_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text_in.valid),
    .in_ready (text_in.ready),
    .in_item  (in_item),
    .out_free (out_free),
    .ctl      (ctl),
    .item     (item)
  );

  utf8tc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .ctl    (ctl),
    .item   (item),
    .result (result)
  );

  utf8tc_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .last       (item.end_of_text),
    .result     (result),
    .out_ready  (result_out.ready),
    .out_valid  (result_out.valid),
    .out_free   (out_free),
    .out_result (out_result)
  );

  assign result_out.verdict    = out_result.verdict;
  assign result_out.valid_utf8 = out_result.valid_utf8;
  assign result_out.all_ascii  = out_result.all_ascii;
  assign result_out.has_cjk    = out_result.has_cjk;

`ifndef NO_ASSERTIONS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !text_in.ready |-> result_out.valid && !result_out.ready)
    else $error("input stalled with output free");

  a_utf8_needs_valid: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.verdict == VERDICT_UTF8 |-> result_out.valid_utf8)
    else $error("UTF-8 verdict on invalid text");

  a_cjk_needs_valid: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.has_cjk |-> result_out.valid_utf8 &&
      result_out.verdict == VERDICT_UTF8)
    else $error("CJK flag on text not judged UTF-8");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(result_out.valid) |-> $past(ctl.advance) && $past(item.end_of_text))
    else $error("result without a last byte");
`endif

endmodule
